/* rtl/mfam_pkg.sv */
// ----------------------------------------------------------------------------
// mfam_pkg: shared types and constants of the fading audio mixer
// Field widths, channel/fade constants, register indexes, the fade phase code
// and the frame record that travels down the row of channel cells.
// ----------------------------------------------------------------------------
package mfam_pkg;

   localparam int CHANNEL_COUNT   = 4;
   localparam int FADE_LENGTH     = 256;   // power of two, 2 .. 4096
   localparam int POS_WIDTH       = (FADE_LENGTH > 2) ? $clog2(FADE_LENGTH) : 1;

   localparam int SAMPLE_WIDTH    = 16;
   localparam int MASK_WIDTH      = 4;
   localparam int GAIN_WIDTH      = 8;
   localparam int MASTER_WIDTH    = 16;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int GAIN_REG_COUNT  = 4;

   // sample * 255 gain, summed over all channels, plus sign
   localparam int SUM_WIDTH  = SAMPLE_WIDTH + GAIN_WIDTH + $clog2(CHANNEL_COUNT + 1) + 1;
   localparam int PROD_WIDTH = SUM_WIDTH + MASTER_WIDTH + 1;

   localparam int SAMPLE_MAX   = 32767;
   localparam int SAMPLE_MIN   = -32768;
   localparam int MASTER_UNITY = 256;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GAIN_A      = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GAIN_B      = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GAIN_C      = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GAIN_D      = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MASTER_GAIN = 3'd4;

   typedef enum logic [1:0] {
      PHASE_IN     = 2'd0,
      PHASE_STEADY = 2'd1,
      PHASE_OUT    = 2'd2
   } phase_type;

   // Each cell consumes the lowest sample and mask bits and shifts the rest
   // down; it shifts its playing bit in at the top.
   typedef struct packed {
      logic [CHANNEL_COUNT-1:0][SAMPLE_WIDTH-1:0] samples;
      logic [CHANNEL_COUNT-1:0]                   start_mask;
      logic [CHANNEL_COUNT-1:0]                   stop_mask;
      logic [CHANNEL_COUNT-1:0]                   playing;
      logic signed [SUM_WIDTH-1:0]                sum;
   } frame_type;

endpackage

/* rtl/mfam_cell.sv */
// ----------------------------------------------------------------------------
// mfam_cell: one channel of the mixer row
// Holds the channel's fade state, weights its sample by the fade ramp, then
// applies the channel gain and adds it to the running sum while playing.
// ----------------------------------------------------------------------------
module mfam_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           enable,
   input  logic                           in_valid,
   input  mfam_pkg::frame_type            in_frame,
   input  logic [mfam_pkg::GAIN_WIDTH-1:0] gain,
   output logic                           out_valid,
   output mfam_pkg::frame_type            out_frame
);
   import mfam_pkg::*;

   logic                    active_ff, active_in;
   phase_type               phase_ff, phase_in;
   logic [POS_WIDTH-1:0]    pos_ff, pos_in;

   logic                    act_eff;
   phase_type               ph_eff;
   logic [POS_WIDTH-1:0]    pos_eff;
   logic [POS_WIDTH:0]      pos_next;
   logic [POS_WIDTH:0]      weight;
   logic signed [SAMPLE_WIDTH+POS_WIDTH+1:0] product;
   logic signed [SAMPLE_WIDTH-1:0]           weighted;
   frame_type               a_frame_in;

   logic                           a_valid_ff;
   frame_type                      a_frame_ff;
   logic signed [SAMPLE_WIDTH-1:0] a_weighted_ff;

   logic [GAIN_WIDTH-1:0]                   gain_eff;
   logic signed [SAMPLE_WIDTH+GAIN_WIDTH:0] scaled;
   frame_type                               b_frame_in;
   logic                                    b_valid_ff;
   frame_type                               b_frame_ff;

   always_comb begin
      act_eff = active_ff;
      ph_eff  = phase_ff;
      pos_eff = pos_ff;
      // start applies before stop
      if (in_frame.start_mask[0] && !act_eff) begin
         act_eff = 1'b1;
         ph_eff  = PHASE_IN;
         pos_eff = '0;
      end
      if (in_frame.stop_mask[0] && act_eff && (ph_eff != PHASE_OUT)) begin
         ph_eff  = PHASE_OUT;
         pos_eff = '0;
      end

      case (ph_eff)
         PHASE_IN:  weight = {1'b0, pos_eff};
         PHASE_OUT: weight = (POS_WIDTH+1)'(FADE_LENGTH - 1) - {1'b0, pos_eff};
         default:   weight = (POS_WIDTH+1)'(FADE_LENGTH);
      endcase
      product  = $signed(in_frame.samples[0]) * $signed({1'b0, weight});
      weighted = SAMPLE_WIDTH'(product / FADE_LENGTH);

      pos_next  = {1'b0, pos_eff} + 1'b1;
      active_in = act_eff;
      phase_in  = ph_eff;
      pos_in    = pos_eff;
      if (act_eff && (ph_eff != PHASE_STEADY)) begin
         if (pos_next == (POS_WIDTH+1)'(FADE_LENGTH)) begin
            pos_in = '0;
            if (ph_eff == PHASE_IN) begin
               phase_in = PHASE_STEADY;
            end else begin
               active_in = 1'b0;
               phase_in  = PHASE_IN;
            end
         end else begin
            pos_in = pos_next[POS_WIDTH-1:0];
         end
      end

      a_frame_in            = in_frame;
      a_frame_in.samples    = in_frame.samples >> SAMPLE_WIDTH;
      a_frame_in.start_mask = in_frame.start_mask >> 1;
      a_frame_in.stop_mask  = in_frame.stop_mask >> 1;
      a_frame_in.playing    = (in_frame.playing >> 1)
                            | (CHANNEL_COUNT'(act_eff) << (CHANNEL_COUNT - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         phase_ff   <= PHASE_IN;
         pos_ff     <= '0;
         a_valid_ff <= 1'b0;
      end else if (enable) begin
         a_valid_ff <= in_valid;
         if (in_valid) begin
            active_ff <= active_in;
            phase_ff  <= phase_in;
            pos_ff    <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a_frame_ff    <= a_frame_in;
         a_weighted_ff <= weighted;
      end
   end

   // gain of 0 or 1 means unity
   always_comb begin
      gain_eff   = (gain > GAIN_WIDTH'(1)) ? gain : GAIN_WIDTH'(1);
      scaled     = a_weighted_ff * $signed({1'b0, gain_eff});
      b_frame_in = a_frame_ff;
      if (a_frame_ff.playing[CHANNEL_COUNT-1]) begin
         b_frame_in.sum = a_frame_ff.sum + SUM_WIDTH'(scaled);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (enable) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         b_frame_ff <= b_frame_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_frame = b_frame_ff;

endmodule

/* rtl/mfam_master.sv */
// ----------------------------------------------------------------------------
// mfam_master: master gain and output saturation
// Scales the finished sum by the Q8.8 master gain when it is above unity,
// then clamps to 16 bits and holds the result in the output register.
// ----------------------------------------------------------------------------
module mfam_master (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               enable,
   input  logic                               in_valid,
   input  mfam_pkg::frame_type                in_frame,
   input  logic [mfam_pkg::MASTER_WIDTH-1:0]  master_gain,
   output logic                               out_valid,
   output logic [mfam_pkg::SAMPLE_WIDTH-1:0]  out_mixed,
   output logic                               out_clipped,
   output logic [mfam_pkg::MASK_WIDTH-1:0]    out_playing
);
   import mfam_pkg::*;

   logic                          m_valid_ff;
   logic                          m_use_ff;
   logic signed [SUM_WIDTH-1:0]   m_sum_ff;
   logic signed [PROD_WIDTH-1:0]  m_prod_ff;
   logic [CHANNEL_COUNT-1:0]      m_playing_ff;

   logic signed [PROD_WIDTH-1:0]  scaled;
   logic [SAMPLE_WIDTH-1:0]       mixed_in;
   logic                          clipped_in;

   logic                          valid_ff;
   logic [SAMPLE_WIDTH-1:0]       mixed_ff;
   logic                          clipped_ff;
   logic [MASK_WIDTH-1:0]         playing_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else if (enable) begin
         m_valid_ff <= in_valid;
         valid_ff   <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         m_use_ff     <= master_gain > MASTER_WIDTH'(MASTER_UNITY);
         m_sum_ff     <= in_frame.sum;
         m_prod_ff    <= in_frame.sum * $signed({1'b0, master_gain});
         m_playing_ff <= in_frame.playing;
         mixed_ff     <= mixed_in;
         clipped_ff   <= clipped_in;
         playing_ff   <= MASK_WIDTH'(m_playing_ff);
      end
   end

   // truncate toward zero, then clamp
   always_comb begin
      scaled = m_use_ff ? (m_prod_ff / MASTER_UNITY) : PROD_WIDTH'(m_sum_ff);
      if (scaled > SAMPLE_MAX) begin
         mixed_in   = SAMPLE_WIDTH'(SAMPLE_MAX);
         clipped_in = 1'b1;
      end else if (scaled < SAMPLE_MIN) begin
         mixed_in   = SAMPLE_WIDTH'(SAMPLE_MIN);
         clipped_in = 1'b1;
      end else begin
         mixed_in   = scaled[SAMPLE_WIDTH-1:0];
         clipped_in = 1'b0;
      end
   end

   assign out_valid   = valid_ff;
   assign out_mixed   = mixed_ff;
   assign out_clipped = clipped_ff;
   assign out_playing = playing_ff;

endmodule

/* rtl/multichannel_fading_audio_mixer_core.sv */
// ----------------------------------------------------------------------------
// multichannel_fading_audio_mixer_core: four-channel mixer with linear fades
// Channel cells in a row build the mix one channel per cell; the master stage
// applies the master gain and saturates.
//
//   channel   direction   handshake              payload
//   req_      in          req_valid/req_ready    samples a..d, start, stop masks
//   rsp_      out         rsp_valid/rsp_ready    mixed sample, clipped, playing
//   csr_      in          csr_valid/csr_ready    register index, write data
//
// One frame is accepted per cycle while req_ready is high. A frame passes
// 2*CHANNEL_COUNT+2 registers (10 here), the first loaded at the accepting
// edge: two stages per channel cell, two in the master stage. A cell updates
// its fade state as the frame passes it. The whole row advances together;
// req_ready drops while a result waits on rsp_ready. csr_ready is always
// high. Reset idles every channel and loads unity gains.
// ----------------------------------------------------------------------------
module multichannel_fading_audio_mixer_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [mfam_pkg::SAMPLE_WIDTH-1:0]     req_sample_a,
   input  logic [mfam_pkg::SAMPLE_WIDTH-1:0]     req_sample_b,
   input  logic [mfam_pkg::SAMPLE_WIDTH-1:0]     req_sample_c,
   input  logic [mfam_pkg::SAMPLE_WIDTH-1:0]     req_sample_d,
   input  logic [mfam_pkg::MASK_WIDTH-1:0]       req_start_mask,
   input  logic [mfam_pkg::MASK_WIDTH-1:0]       req_stop_mask,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [mfam_pkg::SAMPLE_WIDTH-1:0]     rsp_mixed_sample,
   output logic                                  rsp_clipped,
   output logic [mfam_pkg::MASK_WIDTH-1:0]       rsp_playing_mask,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mfam_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [mfam_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);
   import mfam_pkg::*;

   logic [GAIN_WIDTH-1:0]   gain_ff [GAIN_REG_COUNT];
   logic [MASTER_WIDTH-1:0] master_gain_ff;

   logic                    advance;
   logic [SAMPLE_WIDTH-1:0] raw_samples [GAIN_REG_COUNT];
   frame_type               chain_frame [CHANNEL_COUNT+1];
   logic                    chain_valid [CHANNEL_COUNT+1];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < GAIN_REG_COUNT; i++) begin
            gain_ff[i] <= GAIN_WIDTH'(1);
         end
         master_gain_ff <= MASTER_WIDTH'(MASTER_UNITY);
      end else if (csr_valid) begin
         case (csr_index)
            REG_GAIN_A:      gain_ff[0]     <= csr_data[GAIN_WIDTH-1:0];
            REG_GAIN_B:      gain_ff[1]     <= csr_data[GAIN_WIDTH-1:0];
            REG_GAIN_C:      gain_ff[2]     <= csr_data[GAIN_WIDTH-1:0];
            REG_GAIN_D:      gain_ff[3]     <= csr_data[GAIN_WIDTH-1:0];
            REG_MASTER_GAIN: master_gain_ff <= csr_data[MASTER_WIDTH-1:0];
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   // hold the whole row while the output register is full and not taken
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   assign raw_samples[0] = req_sample_a;
   assign raw_samples[1] = req_sample_b;
   assign raw_samples[2] = req_sample_c;
   assign raw_samples[3] = req_sample_d;

   always_comb begin
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
         chain_frame[0].samples[c] = raw_samples[c];
      end
      chain_frame[0].start_mask = req_start_mask[CHANNEL_COUNT-1:0];
      chain_frame[0].stop_mask  = req_stop_mask[CHANNEL_COUNT-1:0];
      chain_frame[0].playing    = '0;
      chain_frame[0].sum        = '0;
   end
   assign chain_valid[0] = req_valid;

   for (genvar c = 0; c < CHANNEL_COUNT; c++) begin : g_cell
      mfam_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (advance),
         .in_valid  (chain_valid[c]),
         .in_frame  (chain_frame[c]),
         .gain      (gain_ff[c]),
         .out_valid (chain_valid[c+1]),
         .out_frame (chain_frame[c+1])
      );
   end

   mfam_master u_master (
      .clock       (clock),
      .reset       (reset),
      .enable      (advance),
      .in_valid    (chain_valid[CHANNEL_COUNT]),
      .in_frame    (chain_frame[CHANNEL_COUNT]),
      .master_gain (master_gain_ff),
      .out_valid   (rsp_valid),
      .out_mixed   (rsp_mixed_sample),
      .out_clipped (rsp_clipped),
      .out_playing (rsp_playing_mask)
   );

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for multichannel_fading_audio_mixer_core
// Drives mixer frames through the request channel with random gaps, stalls the
// result channel at random, and predicts every mix (fade ramps, gains, master
// gain, saturation, playing mask) from its own copy of the channel state.
// ----------------------------------------------------------------------------
module testbench;

   import mfam_pkg::*;

   localparam int PIPE_LATENCY = 2 * CHANNEL_COUNT + 2;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int PHASE_FRAMES = 150;

   typedef struct packed {
      logic [CHANNEL_COUNT-1:0][SAMPLE_WIDTH-1:0] samples;
      logic [MASK_WIDTH-1:0]                      start_mask;
      logic [MASK_WIDTH-1:0]                      stop_mask;
   } stim_type;

   typedef struct packed {
      logic [SAMPLE_WIDTH-1:0] mixed;
      logic                    clipped;
      logic [MASK_WIDTH-1:0]   playing;
   } mix_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [SAMPLE_WIDTH-1:0]     req_sample_a = '0;
   logic [SAMPLE_WIDTH-1:0]     req_sample_b = '0;
   logic [SAMPLE_WIDTH-1:0]     req_sample_c = '0;
   logic [SAMPLE_WIDTH-1:0]     req_sample_d = '0;
   logic [MASK_WIDTH-1:0]       req_start_mask = '0;
   logic [MASK_WIDTH-1:0]       req_stop_mask = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [SAMPLE_WIDTH-1:0]     rsp_mixed_sample;
   logic                        rsp_clipped;
   logic [MASK_WIDTH-1:0]       rsp_playing_mask;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]  csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]   csr_data = '0;

   multichannel_fading_audio_mixer_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_a     (req_sample_a),
      .req_sample_b     (req_sample_b),
      .req_sample_c     (req_sample_c),
      .req_sample_d     (req_sample_d),
      .req_start_mask   (req_start_mask),
      .req_stop_mask    (req_stop_mask),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_mixed_sample (rsp_mixed_sample),
      .rsp_clipped      (rsp_clipped),
      .rsp_playing_mask (rsp_playing_mask),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow registers and channel state of the mixer
   logic [GAIN_WIDTH-1:0]   chan_gain [CHANNEL_COUNT];
   logic [MASTER_WIDTH-1:0] master_gain;
   logic                    chan_on    [CHANNEL_COUNT];
   phase_type               chan_phase [CHANNEL_COUNT];
   logic [POS_WIDTH-1:0]    chan_ramp  [CHANNEL_COUNT];

   stim_type pending_frames [$];
   mix_type  expected_mix [$];
   stim_type on_wire;
   mix_type  oldest;

   logic hold_send = 1'b0;
   logic gaps_on   = 1'b0;
   logic stalls_on = 1'b0;
   int   gap_left   = 0;
   int   stall_left = 0;
   int   cycle_count = 0;
   int   errors = 0;
   int   frames_checked = 0;
   int   frames_clipped = 0;
   int   fades_in_done = 0;
   int   fades_out_done = 0;
   int   reg_writes = 0;

   // stimulus shaping: segments of well-formed traffic with per-channel stop rates
   int   seg_left = 0;
   logic noise_seg = 1'b0;
   int   stop_den [CHANNEL_COUNT];

   initial begin
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
         chan_gain[c]  = 8'd1;
         chan_on[c]    = 1'b0;
         chan_phase[c] = PHASE_IN;
         chan_ramp[c]  = '0;
         stop_den[c]   = 0;
      end
      master_gain = 16'(MASTER_UNITY);
   end

   // Advance the channel state by one frame and return the expected mix.
   function automatic mix_type mix_frame(stim_type f);
      mix_type r;
      int      c;
      int      s;
      int      v;
      int      sum;
      longint  scaled;
      sum = 0;
      r   = '0;
      for (c = 0; c < CHANNEL_COUNT; c++) begin
         s = $signed(f.samples[c]);
         if (f.start_mask[c] && !chan_on[c]) begin
            chan_on[c]    = 1'b1;
            chan_phase[c] = PHASE_IN;
            chan_ramp[c]  = '0;
         end
         if (f.stop_mask[c] && chan_on[c] && chan_phase[c] != PHASE_OUT) begin
            chan_phase[c] = PHASE_OUT;
            chan_ramp[c]  = '0;
         end
         if (chan_on[c]) begin
            r.playing[c] = 1'b1;
            case (chan_phase[c])
               PHASE_IN:  v = s * int'(chan_ramp[c]) / FADE_LENGTH;
               PHASE_OUT: v = s * (FADE_LENGTH - 1 - int'(chan_ramp[c])) / FADE_LENGTH;
               default:   v = s;
            endcase
            if (chan_gain[c] > 1)
               v = v * int'(chan_gain[c]);
            sum += v;
            if (chan_phase[c] != PHASE_STEADY) begin
               if (chan_ramp[c] == FADE_LENGTH - 1) begin
                  chan_ramp[c] = '0;
                  if (chan_phase[c] == PHASE_IN) begin
                     chan_phase[c] = PHASE_STEADY;
                     fades_in_done++;
                  end else begin
                     chan_on[c]    = 1'b0;
                     chan_phase[c] = PHASE_IN;
                     fades_out_done++;
                  end
               end else begin
                  chan_ramp[c] = chan_ramp[c] + 1'b1;
               end
            end
         end
      end
      scaled = sum;
      if (master_gain > MASTER_UNITY)
         scaled = scaled * longint'(master_gain) / MASTER_UNITY;
      if (scaled > SAMPLE_MAX) begin
         scaled    = SAMPLE_MAX;
         r.clipped = 1'b1;
      end else if (scaled < SAMPLE_MIN) begin
         scaled    = SAMPLE_MIN;
         r.clipped = 1'b1;
      end
      r.mixed = scaled[SAMPLE_WIDTH-1:0];
      return r;
   endfunction

   // mostly zero, some short, a few long
   function automatic int pause_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return 16'(SAMPLE_MAX);
         1:       return 16'(SAMPLE_MIN);
         2:       return '0;
         3:       return '1;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic stim_type random_frame();
      stim_type f;
      int       c;
      if (seg_left == 0) begin
         seg_left  = 100;
         noise_seg = ($urandom_range(0, 4) == 0);
         for (c = 0; c < CHANNEL_COUNT; c++) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: stop_den[c] = 0;
               5, 6:          stop_den[c] = 300;
               7, 8:          stop_den[c] = 40;
               default:       stop_den[c] = 6;
            endcase
         end
      end
      seg_left--;
      for (c = 0; c < CHANNEL_COUNT; c++)
         f.samples[c] = pick_sample();
      if (noise_seg) begin
         f.start_mask = 4'($urandom);
         f.stop_mask  = 4'($urandom);
      end else begin
         f.start_mask = '0;
         f.stop_mask  = '0;
         for (c = 0; c < CHANNEL_COUNT; c++) begin
            f.start_mask[c] = ($urandom_range(0, 23) == 0);
            f.stop_mask[c]  = (stop_den[c] != 0) && ($urandom_range(1, stop_den[c]) == 1);
         end
      end
      return f;
   endfunction

   function automatic stim_type make_frame(logic [SAMPLE_WIDTH-1:0] a,
                                           logic [SAMPLE_WIDTH-1:0] b,
                                           logic [SAMPLE_WIDTH-1:0] c,
                                           logic [SAMPLE_WIDTH-1:0] d,
                                           logic [MASK_WIDTH-1:0] start,
                                           logic [MASK_WIDTH-1:0] stop);
      stim_type f;
      f.samples[0] = a;
      f.samples[1] = b;
      f.samples[2] = c;
      f.samples[3] = d;
      f.start_mask = start;
      f.stop_mask  = stop;
      return f;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_mix.push_back(mix_frame(on_wire));
            if (gaps_on)
               gap_left = pause_length();
         end
         if (req_valid && !req_ready) begin
            // hold until the transfer
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (!hold_send && pending_frames.size() != 0) begin
            on_wire = pending_frames.pop_front();
            req_valid      <= 1'b1;
            req_sample_a   <= on_wire.samples[0];
            req_sample_b   <= on_wire.samples[1];
            req_sample_c   <= on_wire.samples[2];
            req_sample_d   <= on_wire.samples[3];
            req_start_mask <= on_wire.start_mask;
            req_stop_mask  <= on_wire.stop_mask;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_mix.size() == 0) begin
            errors++;
            $display("%0t: result with nothing expected, mixed_sample %h", $time,
                     rsp_mixed_sample);
         end else begin
            oldest = expected_mix.pop_front();
            frames_checked++;
            if (oldest.clipped)
               frames_clipped++;
            if (rsp_mixed_sample !== oldest.mixed) begin
               errors++;
               $display("%0t: mixed_sample expected %h actual %h", $time, oldest.mixed,
                        rsp_mixed_sample);
            end
            if (rsp_clipped !== oldest.clipped) begin
               errors++;
               $display("%0t: clipped expected %b actual %b", $time, oldest.clipped,
                        rsp_clipped);
            end
            if (rsp_playing_mask !== oldest.playing) begin
               errors++;
               $display("%0t: playing_mask expected %b actual %b", $time, oldest.playing,
                        rsp_playing_mask);
            end
         end
         if (stalls_on)
            stall_left = pause_length();
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic settle();
      while (pending_frames.size() != 0 || req_valid || expected_mix.size() != 0)
         @(negedge clock);
      repeat (PIPE_LATENCY + 6) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                 input logic [CSR_DATA_WIDTH-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      reg_writes++;
      if (idx < GAIN_REG_COUNT)
         chan_gain[idx] = data[GAIN_WIDTH-1:0];
      else if (idx == REG_MASTER_GAIN)
         master_gain = data;
   endtask

   // upper data bits of the gain writes carry junk that must be dropped
   task automatic apply_setting(input logic [GAIN_REG_COUNT-1:0][GAIN_WIDTH-1:0] gains,
                                input logic [MASTER_WIDTH-1:0] master);
      write_register(REG_GAIN_A, {8'($urandom), gains[0]});
      write_register(REG_GAIN_B, {8'($urandom), gains[1]});
      write_register(REG_GAIN_C, {8'($urandom), gains[2]});
      write_register(REG_GAIN_D, {8'($urandom), gains[3]});
      write_register(REG_MASTER_GAIN, master);
   endtask

   task automatic run_phase(input int count, input logic sender_gaps,
                            input logic receiver_stalls, input logic drain_midway);
      @(negedge clock);
      gaps_on   <= sender_gaps;
      stalls_on <= receiver_stalls;
      repeat (count) pending_frames.push_back(random_frame());
      if (drain_midway) begin
         while (pending_frames.size() > count / 2)
            @(negedge clock);
         hold_send <= 1'b1;
         while (req_valid || expected_mix.size() != 0)
            @(negedge clock);
         hold_send <= 1'b0;
      end
      settle();
   endtask

   initial begin
      logic [GAIN_REG_COUNT-1:0][GAIN_WIDTH-1:0] g;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      gaps_on   <= 1'b1;
      stalls_on <= 1'b1;
      // stop of idle channels, starts, restart of playing channels, stop during
      // fade-in, repeated stop, start and stop together, field extremes
      pending_frames.push_back(make_frame(16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000, 4'h0, 4'hF));
      pending_frames.push_back(make_frame(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 4'h7, 4'h0));
      pending_frames.push_back(make_frame(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 4'h7, 4'h0));
      pending_frames.push_back(make_frame(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 4'h0, 4'h0));
      pending_frames.push_back(make_frame(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 4'h0, 4'h1));
      pending_frames.push_back(make_frame(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 4'h0, 4'h1));
      pending_frames.push_back(make_frame(16'h8000, 16'h8000, 16'h8000, 16'h8000, 4'h8, 4'h8));
      pending_frames.push_back(make_frame(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 4'hF, 4'hF));
      pending_frames.push_back(make_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'h0, 4'h0));
      pending_frames.push_back(make_frame(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 4'h0, 4'h0));
      pending_frames.push_back(make_frame(16'h0001, 16'h8001, 16'h7FFE, 16'h0000, 4'h5, 4'hA));
      pending_frames.push_back(make_frame(16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'hA, 4'h5));
      settle();

      // writes to indexes past the master gain must change nothing
      for (int i = REG_MASTER_GAIN + 1; i < 2 ** CSR_INDEX_WIDTH; i++)
         write_register(CSR_INDEX_WIDTH'(i), 16'($urandom));
      run_phase(PHASE_FRAMES, 1'b0, 1'b0, 1'b0);

      apply_setting({4{8'hFF}}, 16'hFFFF);
      run_phase(PHASE_FRAMES, 1'b1, 1'b1, 1'b1);

      apply_setting({4{8'h00}}, 16'h0000);
      run_phase(PHASE_FRAMES, 1'b1, 1'b0, 1'b0);

      for (int c = 0; c < GAIN_REG_COUNT; c++)
         g[c] = 8'($urandom_range(0, 4));
      apply_setting(g, 16'(MASTER_UNITY + 1));
      run_phase(PHASE_FRAMES, 1'b0, 1'b1, 1'b0);

      for (int c = 0; c < GAIN_REG_COUNT; c++)
         g[c] = 8'($urandom);
      apply_setting(g, 16'($urandom));
      run_phase(PHASE_FRAMES, 1'b1, 1'b1, 1'b0);

      apply_setting({8'd1, 8'd2, 8'd3, 8'd1}, 16'd384);
      run_phase(PHASE_FRAMES, 1'b1, 1'b1, 1'b1);

      $display("Checked %0d mixed frames, %0d of them saturated, over %0d register writes.",
               frames_checked, frames_clipped, reg_writes);
      $display("Fades run to the end: %0d fade-ins, %0d fade-outs.",
               fades_in_done, fades_out_done);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/mfam_pkg.sv
rtl/mfam_cell.sv
rtl/mfam_master.sv
rtl/multichannel_fading_audio_mixer_core.sv
sim/testbench.sv
